// ===== rtl/core/line_frequency_counter_table_defines.svh =====
// Assertion macros for the line frequency counter table.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LINE_FREQUENCY_COUNTER_TABLE_DEFINES_SVH
`define LINE_FREQUENCY_COUNTER_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFCT_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define LFCT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== rtl/core/lfct_pkg.sv =====
// Shared types and constants for the line frequency counter table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package lfct_pkg;

    typedef logic [1:0]  count_t;
    typedef logic [1:0]  cache_id_t;
    typedef logic [63:0] addr_t;
    typedef logic [3:0]  offset_bits_t;

    localparam logic       FUNC_ACCESS = 1'b0;
    localparam logic       FUNC_QUERY  = 1'b1;

    localparam count_t       COUNT_MAX       = 2'd3;
    localparam offset_bits_t MAX_OFFSET_BITS = 4'd12;
    localparam offset_bits_t OFFSET_RESET    = 4'd6;

    // Number of caches tracked; cache ids at or above this are ignored.
    localparam logic [4:0] CACHE_COUNT = 5'd4;

    typedef struct packed {
        logic load_item;
        logic capture_match;
        logic update_fire;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/lfct_channels.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on lfct_pkg for the payload field types.
interface lfct_req_if;
    logic                  valid;
    logic                  ready;
    logic                  func;
    lfct_pkg::cache_id_t   cache_id;
    lfct_pkg::addr_t       byte_address;
    logic                  secure;

    modport source (output valid, output func, output cache_id, output byte_address,
                    output secure, input ready);
    modport sink   (input valid, input func, input cache_id, input byte_address,
                    input secure, output ready);
endinterface

interface lfct_rsp_if;
    logic              valid;
    logic              ready;
    lfct_pkg::count_t  counter_value;
    logic              table_full;

    modport source (output valid, output counter_value, output table_full, input ready);
    modport sink   (input valid, input counter_value, input table_full, output ready);
endinterface

// ===== rtl/core/lfct_ctrl.sv =====
// Sequencing controller: accept, match, then update for each transaction.
// Depends on lfct_pkg for the command and status structs.
module lfct_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfct_pkg::ctrl_sts_t  sts,
    output lfct_pkg::ctrl_cmd_t  cmd
);
    import lfct_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new transaction may enter in the same cycle the previous one retires.
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && sts.out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.load_item     = accept;
        cmd.capture_match = (state_reg == ST_MATCH);
        cmd.update_fire   = (state_reg == ST_UPDATE) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    state_next = accept ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/lfct_datapath.sv =====
// Entry table, parallel per-entry key compare, aging, allocation and result register.
// Depends on lfct_pkg; driven by commands from lfct_ctrl.
module lfct_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lfct_pkg::ctrl_cmd_t    cmd,
    output lfct_pkg::ctrl_sts_t    sts,
    input  logic                   cfg_we,
    input  lfct_pkg::offset_bits_t cfg_wdata,
    input  logic                   in_func,
    input  lfct_pkg::cache_id_t    in_cache_id,
    input  lfct_pkg::addr_t        in_byte_address,
    input  logic                   in_secure,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lfct_pkg::count_t       out_counter_value,
    output logic                   out_table_full
);
    import lfct_pkg::*;

    function automatic count_t count_inc(input count_t c);
        count_inc = (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    // Configuration.
    offset_bits_t offset_bits_reg;
    offset_bits_t offset_eff;
    addr_t        line_mask;

    // Item held while it is being processed.
    logic         item_func_reg;
    cache_id_t    item_cache_reg;
    addr_t        item_line_reg;
    logic         item_secure_reg;
    logic         item_ok_reg;

    // Entry storage.
    logic [TABLE_DEPTH-1:0] valid_reg;
    cache_id_t              cache_reg  [TABLE_DEPTH];
    addr_t                  line_reg   [TABLE_DEPTH];
    logic                   secure_reg [TABLE_DEPTH];
    count_t                 count_reg  [TABLE_DEPTH];

    // Match stage.
    logic [TABLE_DEPTH-1:0] match_now;
    logic [TABLE_DEPTH-1:0] same_now;
    count_t                 hit_count_now;
    logic [TABLE_DEPTH-1:0] match_reg;
    logic [TABLE_DEPTH-1:0] same_reg;
    count_t                 hit_count_reg;

    // Update stage.
    logic [TABLE_DEPTH-1:0] age;
    logic [TABLE_DEPTH-1:0] valid_after;
    logic [TABLE_DEPTH-1:0] alloc_onehot;
    logic                   hit;
    logic                   do_access;
    count_t                 value_next;
    logic                   full_next;

    // Result register.
    logic   out_valid_reg;
    count_t out_value_reg;
    logic   out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            offset_bits_reg <= cfg_wdata;
        end
    end

    assign offset_eff = (offset_bits_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_reg;
    assign line_mask  = ~((64'd1 << offset_eff) - 64'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_func_reg   <= in_func;
            item_cache_reg  <= in_cache_id;
            item_line_reg   <= in_byte_address & line_mask;
            item_secure_reg <= in_secure;
            item_ok_reg     <= ({3'b000, in_cache_id} < CACHE_COUNT);
        end
    end

    always_comb
    begin
        hit_count_now = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            same_now[i]  = valid_reg[i] && (cache_reg[i] == item_cache_reg);
            match_now[i] = same_now[i] && (line_reg[i] == item_line_reg)
                           && (secure_reg[i] == item_secure_reg);
            if (match_now[i])
            begin
                hit_count_now = hit_count_now | count_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_match)
        begin
            match_reg     <= match_now;
            same_reg      <= same_now;
            hit_count_reg <= hit_count_now;
        end
    end

    // Entries of the same cache with another key lose one count; at one they are freed.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            age[i]         = same_reg[i] && !match_reg[i];
            valid_after[i] = valid_reg[i] && !(age[i] && (count_reg[i] == count_t'(1)));
        end
    end

    // Lowest free slot: clear bit of valid_after isolated by the carry of an increment.
    assign alloc_onehot = ~valid_after & (valid_after + TABLE_DEPTH'(1));
    assign hit          = |match_reg;
    assign do_access    = item_ok_reg && (item_func_reg == FUNC_ACCESS);

    always_comb
    begin
        value_next = '0;
        full_next  = 1'b0;
        if (item_ok_reg)
        begin
            if (item_func_reg == FUNC_QUERY)
            begin
                value_next = hit ? hit_count_reg : count_t'(0);
            end
            else
            begin
                value_next = hit ? count_inc(hit_count_reg) : count_t'(1);
                full_next  = !hit && (alloc_onehot == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update_fire && do_access)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                priority if (match_reg[i])
                begin
                    valid_reg[i] <= 1'b1;
                end
                else if (alloc_onehot[i] && !hit)
                begin
                    valid_reg[i] <= 1'b1;
                end
                else
                begin
                    valid_reg[i] <= valid_after[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update_fire && do_access)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                priority if (match_reg[i])
                begin
                    count_reg[i] <= count_inc(count_reg[i]);
                end
                else if (alloc_onehot[i] && !hit)
                begin
                    cache_reg[i]  <= item_cache_reg;
                    line_reg[i]   <= item_line_reg;
                    secure_reg[i] <= item_secure_reg;
                    count_reg[i]  <= count_t'(1);
                end
                else if (age[i])
                begin
                    count_reg[i] <= count_reg[i] - count_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update_fire)
        begin
            out_value_reg <= value_next;
            out_full_reg  <= full_next;
        end
    end

    assign sts.out_free       = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign out_counter_value  = out_value_reg;
    assign out_table_full     = out_full_reg;

endmodule

// ===== rtl/core/line_frequency_counter_table.sv =====
// Line frequency counter table: 2-bit saturating counters per cache line.
// The request is registered on acceptance; the match state compares all entries;
// the update state ages, allocates, increments and loads the result register,
// waiting while the output is held. A new request can enter once the update fires.
// Reset: all entry valid bits clear at once (no clearing pass); line offset returns to 6.
module line_frequency_counter_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  lfct_pkg::offset_bits_t cfg_wdata,
    lfct_req_if.sink               req,
    lfct_rsp_if.source             rsp
);
    import lfct_pkg::*;

    `include "line_frequency_counter_table_defines.svh"

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      in_ready;

    lfct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_func           (req.func),
        .in_cache_id       (req.cache_id),
        .in_byte_address   (req.byte_address),
        .in_secure         (req.secure),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_counter_value (rsp.counter_value),
        .out_table_full    (rsp.table_full)
    );

    assign req.ready = in_ready;

    `LFCT_ASSERT_NEXT(a_accept_then_match, req.valid && req.ready, cmd.capture_match)
    `LFCT_ASSERT_NEXT(a_match_then_update, cmd.capture_match, cmd.update_fire == sts.out_free)
    `LFCT_ASSERT_NEXT(a_update_gives_result, cmd.update_fire, rsp.valid)
    `LFCT_ASSERT_IMPLY(a_full_reports_one, rsp.valid && rsp.table_full, rsp.counter_value == 2'd1)

endmodule
